// ===== hw/rtl/lorf_pkg.sv =====
package lorf_pkg;

  localparam logic [31:0] CRC_POLY      = 32'hedb88320;
  localparam logic [31:0] CRC_SEED      = 32'hffffffff;
  localparam logic [7:0]  CRC_PREFIX    = 8'ha2;
  localparam logic [7:0]  ID_WIRELESS   = 8'h31;
  localparam logic [7:0]  ID_WIRED      = 8'h02;
  localparam logic [7:0]  WL_TAG        = 8'h10;
  localparam logic [7:0]  FLAG_COLOR    = 8'h14;
  localparam logic [7:0]  FLAG_RESTORE  = 8'h08;
  localparam logic [7:0]  LED_ON_BIT    = 8'h20;
  localparam logic [7:0]  LED_MASK      = 8'h1f;
  localparam logic [6:0]  WIRELESS_LEN  = 7'd78;
  localparam logic [6:0]  MIN_WIRED_LEN = 7'd48;
  localparam logic [6:0]  CRC_END       = 7'd74;
  localparam int          BYTE_CAP      = 80;

  // register indexes on the config port
  localparam logic [1:0] REG_LINK_IS_WIRELESS    = 2'd0;
  localparam logic [1:0] REG_WIRED_REPORT_LENGTH = 2'd1;
  localparam logic [1:0] REG_PLAYER_LED_MASK     = 2'd2;

  typedef struct packed {
    logic       restore_mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [31:0] report_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // reflected crc-32, one byte folded in
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_START = crc_byte(CRC_SEED, CRC_PREFIX);

endpackage

// ===== hw/rtl/led_output_report_framer.sv =====
// channel   ports                          handshake
// -------   -----------------------------  ---------------------------------
// input     in_item                        taken when start && !busy
// result    out_item                       shown for one cycle with out_strobe
// config    cfg_we, cfg_index, cfg_wdata   written when cfg_we is high
//
// one report byte is built per cycle and shifted into a word register, so a
// word holds 4 bytes and a report fills its length in bytes rounded up to a
// multiple of 4. the byte sequencer and the byte-wide crc step set this rate.
// a result is registered and follows in the cycle after its last byte.
// synchronous active-low reset returns the sequencer to idle and loads the
// register reset values. the receiver cannot stall; busy holds off new items
// while a report is framed.
module led_output_report_framer #(
  parameter int MAX_WIRED_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lorf_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_wdata,
  output logic                out_strobe,
  output lorf_pkg::out_item_t out_item
);
  import lorf_pkg::*;

  // longest wired report after the parameter and the 20-word cap
  localparam int WIRED_MAX_INT = (MAX_WIRED_BYTES < BYTE_CAP) ? MAX_WIRED_BYTES : BYTE_CAP;
  localparam logic [6:0] WIRED_MAX = 7'(WIRED_MAX_INT);

  // config registers
  logic       link_is_wireless_r;
  logic [6:0] wired_report_length_r;
  logic [4:0] player_led_mask_r;

  // sequencer and datapath
  state_t      state_r, state_nxt;
  logic [6:0]  addr_r, addr_nxt;        // byte address inside the report
  logic [6:0]  len_r, len_nxt;          // report length in bytes
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] word_r, word_nxt;        // byte shift register
  in_item_t    item_r, item_nxt;
  logic        out_strobe_r, out_strobe_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic [6:0]  len_calc;
  logic [7:0]  rep_byte;                // report byte at addr_r before masking
  logic [7:0]  cur_byte;
  logic [6:0]  remain;
  logic [6:0]  pos;                     // address relative to the shifted fields
  logic [31:0] crc_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_is_wireless_r    <= 1'b0;
      wired_report_length_r <= MIN_WIRED_LEN;
      player_led_mask_r     <= 5'd31;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINK_IS_WIRELESS:    link_is_wireless_r    <= cfg_wdata[0];
        REG_WIRED_REPORT_LENGTH: wired_report_length_r <= cfg_wdata;
        REG_PLAYER_LED_MASK:     player_led_mask_r     <= cfg_wdata[4:0];
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  // length clamp, evaluated when an item is taken
  always_comb begin
    if (link_is_wireless_r) begin
      len_calc = WIRELESS_LEN;
    end else if (wired_report_length_r < MIN_WIRED_LEN) begin
      len_calc = MIN_WIRED_LEN;
    end else if (wired_report_length_r > WIRED_MAX) begin
      len_calc = WIRED_MAX;
    end else begin
      len_calc = wired_report_length_r;
    end
  end

  assign crc_fin = ~crc_r;

  // byte generator: header bytes, then fields shifted by two and the crc in wireless
  always_comb begin
    pos      = link_is_wireless_r ? (addr_r - 7'd2) : addr_r;
    rep_byte = 8'h00;
    if (addr_r == 7'd0) begin
      rep_byte = link_is_wireless_r ? ID_WIRELESS : ID_WIRED;
    end else if (link_is_wireless_r && addr_r == 7'd2) begin
      rep_byte = WL_TAG;
    end else if (link_is_wireless_r && addr_r >= CRC_END) begin
      unique case (addr_r[1:0])
        2'd2:    rep_byte = crc_fin[7:0];
        2'd3:    rep_byte = crc_fin[15:8];
        2'd0:    rep_byte = crc_fin[23:16];
        default: rep_byte = crc_fin[31:24];
      endcase
    end else if (pos == 7'd2) begin
      rep_byte = item_r.restore_mode ? FLAG_RESTORE : FLAG_COLOR;
    end else if (!item_r.restore_mode) begin
      unique case (pos)
        7'd44:   rep_byte = ({3'd0, player_led_mask_r} & LED_MASK) | LED_ON_BIT;
        7'd45:   rep_byte = item_r.red;
        7'd46:   rep_byte = item_r.green;
        7'd47:   rep_byte = item_r.blue;
        default: rep_byte = 8'h00;
      endcase
    end
    // pad bytes past the end of the report read as zero
    cur_byte = (addr_r < len_r) ? rep_byte : 8'h00;
  end

  // bytes left from the start of the current word
  assign remain = len_r - {addr_r[6:2], 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    crc_r      <= crc_nxt;
    word_r     <= word_nxt;
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    crc_nxt        = crc_r;
    word_nxt       = word_r;
    item_nxt       = item_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          addr_nxt  = 7'd0;
          len_nxt   = len_calc;
          crc_nxt   = CRC_START;
          item_nxt  = in_item;
        end
      end
      ST_RUN: begin
        word_nxt = {cur_byte, word_r[31:8]};
        // crc covers everything ahead of its own four bytes
        if (link_is_wireless_r && addr_r < CRC_END) begin
          crc_nxt = crc_byte(crc_r, cur_byte);
        end
        addr_nxt = addr_r + 7'd1;
        if (addr_r[1:0] == 2'd3) begin
          out_strobe_nxt           = 1'b1;
          out_item_nxt.report_word = {cur_byte, word_r[31:8]};
          out_item_nxt.valid_bytes = (remain >= 7'd4) ? 3'd4 : remain[2:0];
          out_item_nxt.last_word   = (remain <= 7'd4);
          if (remain <= 7'd4) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef NO_ASSERTIONS
  // an accepted item always starts a report
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but sequencer stayed idle");

  // the final word leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last_word) |-> !busy)
    else $error("sequencer still busy after final word");

  // only the final word may be partial
  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last_word) |-> (out_item.valid_bytes == 3'd4))
    else $error("partial word before the end of the report");

  // results come only out of a running report
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a report in progress");
`endif

endmodule

// ===== sim/tb_led_output_report_framer.sv =====
`timescale 1ns / 100ps

module tb_led_output_report_framer;
  import lorf_pkg::*;

  localparam int WIRED_CEIL  = 64;
  localparam int ITEM_TARGET = 370;
  // cycles with neither an item taken nor a word shown before giving up
  localparam int STALL_LIMIT = 4000;
  // index past the end of the register list, writes must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_item   = '0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;
  logic       out_strobe;
  out_item_t  out_item;

  // shadow of the block's registers, at reset values
  logic       cfg_wireless  = 1'b0;
  logic [6:0] cfg_wired_len = MIN_WIRED_LEN;
  logic [4:0] cfg_led_mask  = 5'h1f;

  in_item_t  requests_pending[$];
  out_item_t report_words_due[$];
  int items_queued = 0;
  int fault_count  = 0;
  int stall_cycles = 0;
  int gap_left     = 0;
  int calm_left    = 0;

  led_output_report_framer #(
    .MAX_WIRED_BYTES(WIRED_CEIL)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // reflected crc, one data bit at a time, lsb first
  function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] r;
    int b;
    r = acc;
    for (b = 0; b < 8; b++) begin
      if (r[0] ^ data[b]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  // builds the whole report for one request and queues its words
  function automatic void forecast_report(input in_item_t req);
    logic [7:0]  rep [0:BYTE_CAP-1];
    logic [31:0] crc;
    out_item_t   w;
    int nbytes;
    int ofs;
    int n_words;
    int k;
    for (k = 0; k < BYTE_CAP; k++) rep[k] = 8'h00;
    if (cfg_wireless) begin
      nbytes = int'(WIRELESS_LEN);
      rep[0] = ID_WIRELESS;
      rep[2] = WL_TAG;
      ofs = 3;
    end else begin
      // short lengths round up to the minimum, long ones clip at the ceiling
      nbytes = int'(cfg_wired_len);
      if (nbytes < MIN_WIRED_LEN) nbytes = int'(MIN_WIRED_LEN);
      if (nbytes > WIRED_CEIL) nbytes = WIRED_CEIL;
      if (nbytes > BYTE_CAP) nbytes = BYTE_CAP;
      rep[0] = ID_WIRED;
      ofs = 1;
    end
    if (req.restore_mode) begin
      // restore leaves led and colour bytes at zero
      rep[ofs + 1] = FLAG_RESTORE;
    end else begin
      rep[ofs + 1]  = FLAG_COLOR;
      rep[ofs + 43] = (LED_MASK & {3'b000, cfg_led_mask}) | LED_ON_BIT;
      rep[ofs + 44] = req.red;
      rep[ofs + 45] = req.green;
      rep[ofs + 46] = req.blue;
    end
    if (cfg_wireless) begin
      // prefix byte first, then everything ahead of the crc field
      crc = crc_fold(CRC_SEED, CRC_PREFIX);
      for (k = 0; k < CRC_END; k++) crc = crc_fold(crc, rep[k]);
      crc = ~crc;
      rep[CRC_END]     = crc[7:0];
      rep[CRC_END + 1] = crc[15:8];
      rep[CRC_END + 2] = crc[23:16];
      rep[CRC_END + 3] = crc[31:24];
    end
    n_words = (nbytes + 3) / 4;
    for (k = 0; k < n_words; k++) begin
      // bytes past the report end stay zero in a partial last word
      w.report_word = {rep[4*k+3], rep[4*k+2], rep[4*k+1], rep[4*k]};
      w.valid_bytes = (nbytes - 4*k >= 4) ? 3'd4 : 3'(nbytes - 4*k);
      w.last_word   = (k == n_words - 1);
      report_words_due.insert(report_words_due.size(), w);
    end
  endfunction

  // sender idle time: mostly none or short, sometimes long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(5, 30);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    // long gaps land on every phase of a report
    return $urandom_range(5, 95);
  endfunction

  function automatic logic [6:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 7'($urandom_range(48, 64));
    if (r < 8) return 7'($urandom_range(0, 47));
    return 7'($urandom_range(65, 127));
  endfunction

  task automatic note_fault(input string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  task automatic queue_req(input logic rm, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    requests_pending.insert(requests_pending.size(), {rm, r, g, b});
    items_queued++;
  endtask

  task automatic queue_random_req();
    logic       rm;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    rm = ($urandom_range(0, 3) == 0);
    r  = 8'($urandom_range(0, 255));
    g  = 8'($urandom_range(0, 255));
    b  = 8'($urandom_range(0, 255));
    queue_req(rm, r, g, b);
  endtask

  // register write, only ever issued while the framer is idle
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LINK_IS_WIRELESS:    cfg_wireless  = val[0];
      REG_WIRED_REPORT_LENGTH: cfg_wired_len = val;
      REG_PLAYER_LED_MASK:     cfg_led_mask  = val[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every item is taken and every word has come back
  task automatic settle();
    @(negedge clk);
    while (requests_pending.size() > 0 || start || busy || report_words_due.size() > 0)
      @(negedge clk);
    // a word is registered behind its last byte
    repeat (4) @(negedge clk);
  endtask

  // driver: holds start until taken, then waits out a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        forecast_report(in_item);
        gap_left = pick_gap();
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (requests_pending.size() > 0) begin
          in_item <= requests_pending.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word against the oldest expected one, plus watchdog
  always @(posedge clk) begin
    out_item_t due;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_led_output_report_framer: done, errors");
        $finish;
      end else if (out_strobe) begin
        if (report_words_due.size() == 0) begin
          note_fault($sformatf("unexpected word %h bytes %0d last %b",
                               out_item.report_word, out_item.valid_bytes,
                               out_item.last_word));
        end else begin
          due = report_words_due.pop_front();
          if (due.report_word !== out_item.report_word ||
              due.valid_bytes !== out_item.valid_bytes ||
              due.last_word !== out_item.last_word) begin
            note_fault($sformatf(
              "word mismatch: expected %h bytes %0d last %b, got %h bytes %0d last %b",
              due.report_word, due.valid_bytes, due.last_word,
              out_item.report_word, out_item.valid_bytes, out_item.last_word));
          end
        end
      end
    end
  end

  initial begin
    int n;
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: wired, 48 bytes, all player leds
    queue_req(1'b0, 8'h00, 8'h00, 8'h00);
    queue_req(1'b0, 8'hff, 8'hff, 8'hff);
    queue_req(1'b1, 8'hff, 8'hff, 8'hff);
    queue_req(1'b0, 8'h80, 8'h01, 8'h7f);
    settle();

    // length below the minimum, no player leds
    write_reg(REG_WIRED_REPORT_LENGTH, 7'd0);
    write_reg(REG_PLAYER_LED_MASK, 7'd0);
    queue_req(1'b0, 8'h12, 8'h34, 8'h56);
    queue_req(1'b1, 8'h00, 8'h00, 8'h00);
    settle();

    // length above the ceiling, mask with stray upper bits
    write_reg(REG_WIRED_REPORT_LENGTH, 7'd127);
    write_reg(REG_PLAYER_LED_MASK, 7'h7f);
    queue_req(1'b0, 8'hff, 8'h00, 8'hff);
    queue_req(1'b0, 8'h00, 8'hff, 8'h00);
    settle();

    // partial last words
    write_reg(REG_WIRED_REPORT_LENGTH, 7'd49);
    queue_req(1'b0, 8'ha5, 8'h5a, 8'hc3);
    settle();
    write_reg(REG_WIRED_REPORT_LENGTH, 7'd50);
    queue_req(1'b1, 8'h3c, 8'hc3, 8'h99);
    settle();
    write_reg(REG_WIRED_REPORT_LENGTH, 7'd51);
    queue_req(1'b0, 8'h01, 8'h02, 8'h03);
    settle();
    write_reg(REG_WIRED_REPORT_LENGTH, 7'd63);
    queue_req(1'b0, 8'hfe, 8'hdc, 8'hba);
    settle();
    write_reg(REG_WIRED_REPORT_LENGTH, 7'd65);
    queue_req(1'b0, 8'h55, 8'haa, 8'h0f);
    settle();

    // write past the register list, nothing may change
    write_reg(REG_UNUSED, 7'h7f);
    queue_req(1'b0, 8'h10, 8'h20, 8'h30);
    settle();

    // wireless form with crc, both led mask extremes
    write_reg(REG_LINK_IS_WIRELESS, 7'h7f);
    write_reg(REG_WIRED_REPORT_LENGTH, 7'd48);
    write_reg(REG_PLAYER_LED_MASK, 7'h1f);
    queue_req(1'b0, 8'h00, 8'h00, 8'h00);
    queue_req(1'b0, 8'hff, 8'hff, 8'hff);
    queue_req(1'b1, 8'hff, 8'hff, 8'hff);
    settle();
    write_reg(REG_PLAYER_LED_MASK, 7'h60);
    queue_req(1'b0, 8'h7f, 8'h80, 8'h01);
    settle();

    // random phases: reprogram some registers, then a batch of requests
    while (items_queued < ITEM_TARGET) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_LINK_IS_WIRELESS, 7'($urandom_range(0, 127)));
          1:       write_reg(REG_WIRED_REPORT_LENGTH, pick_length());
          2:       write_reg(REG_PLAYER_LED_MASK, 7'($urandom_range(0, 127)));
          default: write_reg(REG_UNUSED, 7'($urandom_range(0, 127)));
        endcase
      end
      n = $urandom_range(4, 20);
      for (k = 0; k < n; k++) queue_random_req();
      settle();
    end

    // tail: let any stray word show up
    repeat (20) @(negedge clk);
    if (fault_count == 0 && report_words_due.size() == 0) begin
      $display("tb_led_output_report_framer: done, clean");
    end else begin
      $display("tb_led_output_report_framer: done, errors");
    end
    $finish;
  end

endmodule

// ===== led_output_report_framer.f =====
hw/rtl/lorf_pkg.sv
hw/rtl/led_output_report_framer.sv
sim/tb_led_output_report_framer.sv
